FILE: hdl/nalu_pkg.sv
// Shared types and constants for the nibble ALU micro-op datapath.
package nalu_pkg;

	typedef enum logic [2:0] {
		OP_BEGIN   = 3'd0,
		OP_LATCH   = 3'd1,
		OP_LOAD    = 3'd2,
		OP_SET_A   = 3'd3,
		OP_SET_CIN = 3'd4,
		OP_RUN     = 3'd5,
		OP_QUERY   = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_DAA   = 2'd1,
		KIND_TCS   = 2'd2,
		KIND_KBP   = 2'd3
	} kind_t;

	localparam logic [3:0] NIB_ALL   = 4'hF;
	localparam logic [3:0] NIB_ZERO  = 4'h0;
	localparam logic [3:0] DAA_LIMIT = 4'd9;
	localparam logic [3:0] DAA_ADJ   = 4'd6;
	localparam logic [3:0] TCS_VALUE = 4'd9;
	localparam logic [3:0] KBP_MAX_PASS = 4'd2;
	localparam logic [3:0] KBP_IN_4  = 4'd4;
	localparam logic [3:0] KBP_OUT_4 = 4'd3;
	localparam logic [3:0] KBP_IN_8  = 4'd8;
	localparam logic [3:0] KBP_OUT_8 = 4'd4;

	typedef struct packed {
		op_t        operation;
		logic [3:0] bus_value;
		logic       invert;
		logic       force_one;
		logic       save_acc;
		logic       save_carry;
		logic       shift_left;
		logic       shift_right;
		logic       opa_high;
		kind_t      insn_kind;
	} req_item_t;

	typedef struct packed {
		logic [3:0] initializer_value;
		logic [3:0] accumulator;
		logic       carry_flag;
		logic [3:0] latched_acc;
		logic       latched_carry;
		logic [3:0] adder_sum;
		logic       acc_is_zero;
		logic       sum_is_zero;
	} rsp_item_t;

	typedef struct packed {
		logic [3:0] acc_reg;
		logic [3:0] temp_reg;
		logic       carry_reg;
		logic [3:0] adder_a;
		logic       adder_cin;
		logic [3:0] acc_latch;
		logic       carry_latch;
		logic [3:0] sum_reg;
	} alu_state_t;

endpackage

FILE: hdl/nalu_exec.sv
// Next-state and result logic for one ALU micro-operation.
module nalu_exec import nalu_pkg::*; (
	input  req_item_t  item,
	input  alu_state_t cur,
	output alu_state_t nxt,
	output rsp_item_t  result
);

	logic [3:0] b_opnd;
	logic [4:0] sum_full;
	logic [3:0] sum;
	logic       daa_hit;
	logic       daa_hit_nxt;
	logic [3:0] init_val;

	assign b_opnd   = item.invert ? ~cur.temp_reg : cur.temp_reg;
	assign sum_full = {1'b0, cur.adder_a} + {1'b0, b_opnd} + {4'b0000, cur.adder_cin};
	assign sum      = sum_full[3:0];
	assign daa_hit  = cur.carry_latch || (cur.acc_latch > DAA_LIMIT);

	always_comb begin
		nxt = cur;
		unique case (item.operation)
			OP_BEGIN: begin
				nxt.adder_a   = NIB_ZERO;
				nxt.temp_reg  = NIB_ALL;
				nxt.adder_cin = 1'b0;
			end
			OP_LATCH: begin
				nxt.acc_latch   = cur.acc_reg;
				nxt.carry_latch = cur.carry_reg;
			end
			OP_LOAD: begin
				nxt.temp_reg = item.bus_value;
			end
			OP_SET_A: begin
				nxt.adder_a = item.invert ? ~cur.acc_reg : cur.acc_reg;
			end
			OP_SET_CIN: begin
				nxt.adder_cin = item.force_one | (cur.carry_reg ^ item.invert);
			end
			OP_RUN: begin
				nxt.sum_reg = sum;
				if (item.shift_left) begin
					nxt.carry_reg = sum[3];
					nxt.acc_reg   = {sum[2:0], cur.carry_latch};
				end else if (item.shift_right) begin
					nxt.carry_reg = sum[0];
					nxt.acc_reg   = {cur.carry_latch, sum[3:1]};
				end else begin
					if (item.save_acc)
						nxt.acc_reg = sum;
					if (item.save_carry)
						nxt.carry_reg = ((item.insn_kind == KIND_DAA) && daa_hit) | sum_full[4];
				end
			end
			default: begin
			end
		endcase
	end

	// initializer uses the latch contents after this operation
	assign daa_hit_nxt = nxt.carry_latch || (nxt.acc_latch > DAA_LIMIT);

	always_comb begin
		init_val = NIB_ALL;
		if (!item.opa_high) begin
			init_val = NIB_ZERO;
		end else begin
			case (item.insn_kind)
				KIND_DAA: init_val = daa_hit_nxt ? DAA_ADJ : NIB_ZERO;
				KIND_TCS: init_val = TCS_VALUE;
				KIND_KBP: begin
					if (nxt.acc_latch == KBP_IN_4)
						init_val = KBP_OUT_4;
					else if (nxt.acc_latch == KBP_IN_8)
						init_val = KBP_OUT_8;
					else if (nxt.acc_latch > KBP_MAX_PASS)
						init_val = NIB_ALL;
					else
						init_val = nxt.acc_latch;
				end
				default: init_val = NIB_ALL;
			endcase
		end
	end

	always_comb begin
		result.initializer_value = init_val;
		result.accumulator       = nxt.acc_reg;
		result.carry_flag        = nxt.carry_reg;
		result.latched_acc       = nxt.acc_latch;
		result.latched_carry     = nxt.carry_latch;
		result.adder_sum         = nxt.sum_reg;
		result.acc_is_zero       = (nxt.acc_latch == NIB_ZERO);
		result.sum_is_zero       = (nxt.sum_reg == NIB_ZERO);
	end

endmodule

FILE: hdl/nibble_alu_micro_op_datapath.sv
// Top level of the nibble ALU micro-op datapath.
// Request path: input reg, then result reg, which holds the response.
// Throughput: one micro-op per cycle while rsp is not stalled.
// ALU state updates as an op leaves the input reg.
// Backpressure on rsp stalls the input reg, which then stalls req.
// Reset clears the ALU registers and both valid flags; payload regs are not reset.
module nibble_alu_micro_op_datapath import nalu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req_data,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp_data
);

	logic       valid_s1;
	req_item_t  item_s1;
	logic       rsp_valid_q;
	rsp_item_t  rsp_q;
	alu_state_t state_q;
	alu_state_t state_nxt;
	rsp_item_t  result;
	logic       advance;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req_ready)
			valid_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready)
			item_s1 <= req_data;
	end

	nalu_exec u_exec (
		.item   (item_s1),
		.cur    (state_q),
		.nxt    (state_nxt),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			rsp_q <= result;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

FILE: hdl/nalu_checker.sv
// Port-level checks for the nibble ALU micro-op datapath, bound to the top level.
module nalu_checker import nalu_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input req_item_t req_data,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input rsp_item_t rsp_data
);

	logic rsp_xfer;
	logic req_xfer;

	assign rsp_xfer = rsp_valid && rsp_ready;
	assign req_xfer = req_valid && req_ready;

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	a_zero_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.acc_is_zero == (rsp_data.latched_acc == NIB_ZERO)) &&
			(rsp_data.sum_is_zero == (rsp_data.adder_sum == NIB_ZERO)))
		else $error("zero flag mismatch");

	// latches only move by copying the previous accumulator and carry
	a_acc_latch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_xfer ##1 rsp_xfer |-> (rsp_data.latched_acc == $past(rsp_data.latched_acc)) ||
			(rsp_data.latched_acc == $past(rsp_data.accumulator)))
		else $error("latched accumulator jumped");

	a_carry_latch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_xfer ##1 rsp_xfer |-> (rsp_data.latched_carry == $past(rsp_data.latched_carry)) ||
			(rsp_data.latched_carry == $past(rsp_data.carry_flag)))
		else $error("latched carry jumped");

	// an empty pipe cannot produce a response
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(!rsp_valid && !req_xfer) ##1 (!rsp_valid && !req_xfer) |=> !rsp_valid)
		else $error("response without request");

endmodule

bind nibble_alu_micro_op_datapath nalu_checker u_nalu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req_data  (req_data),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp_data  (rsp_data)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the nibble ALU micro-op datapath: directed ops, then random streams.
`timescale 1ns / 100ps

module tb_top;
	import nalu_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned ITEM_TARGET  = 1900;
	localparam int unsigned HOLD_AFTER   = 600;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned MAX_REPORTS  = 10;
	localparam int unsigned RAW_W        = $bits(req_item_t);
	localparam logic [2:0]  OP_UNUSED    = 3'd7;

	// flag order: invert, force_one, save_acc, save_carry, shift_left, shift_right, opa_high
	localparam logic [6:0] F_INV = 7'b1000000;
	localparam logic [6:0] F_ONE = 7'b0100000;
	localparam logic [6:0] F_SA  = 7'b0010000;
	localparam logic [6:0] F_SC  = 7'b0001000;
	localparam logic [6:0] F_SHL = 7'b0000100;
	localparam logic [6:0] F_SHR = 7'b0000010;
	localparam logic [6:0] F_OPA = 7'b0000001;

	typedef enum logic [1:0] {
		RX_STEADY,
		RX_COIN,
		RX_SPARSE
	} rx_mode_t;

	class alu_status_checker;
		logic [3:0] acc, temp, a_in, acc_l, sum;
		logic       cy, cin, cy_l;
		rsp_item_t  expected_status_q[$];
		int unsigned errors;

		function new();
			acc = '0; temp = '0; a_in = '0; acc_l = '0; sum = '0;
			cy = 1'b0; cin = 1'b0; cy_l = 1'b0;
			errors = 0;
		endfunction

		function rsp_item_t predict_status(req_item_t op);
			logic [3:0] b;
			logic [4:0] s;
			logic       daa_hit;
			rsp_item_t  r;
			case (op.operation)
				OP_BEGIN: begin
					a_in = NIB_ZERO;
					temp = NIB_ALL;
					cin  = 1'b0;
				end
				OP_LATCH: begin
					acc_l = acc;
					cy_l  = cy;
				end
				OP_LOAD:    temp = op.bus_value;
				OP_SET_A:   a_in = op.invert ? ~acc : acc;
				OP_SET_CIN: cin = op.force_one ? 1'b1 : (cy ^ op.invert);
				OP_RUN: begin
					b   = op.invert ? ~temp : temp;
					s   = {1'b0, a_in} + {1'b0, b} + {4'b0, cin};
					sum = s[3:0];
					if (op.shift_left) begin
						cy  = sum[3];
						acc = {sum[2:0], cy_l};
					end else if (op.shift_right) begin
						cy  = sum[0];
						acc = {cy_l, sum[3:1]};
					end else begin
						if (op.save_acc)
							acc = sum;
						if (op.save_carry)
							cy = (op.insn_kind == KIND_DAA && (cy_l || acc_l > DAA_LIMIT)) ?
								1'b1 : s[4];
					end
				end
				default: ;
			endcase
			daa_hit = cy_l || (acc_l > DAA_LIMIT);
			if (!op.opa_high)
				r.initializer_value = NIB_ZERO;
			else begin
				case (op.insn_kind)
					KIND_DAA: r.initializer_value = daa_hit ? DAA_ADJ : NIB_ZERO;
					KIND_TCS: r.initializer_value = TCS_VALUE;
					KIND_KBP: begin
						if (acc_l == KBP_IN_4)
							r.initializer_value = KBP_OUT_4;
						else if (acc_l == KBP_IN_8)
							r.initializer_value = KBP_OUT_8;
						else if (acc_l > KBP_MAX_PASS)
							r.initializer_value = NIB_ALL;
						else
							r.initializer_value = acc_l;
					end
					default: r.initializer_value = NIB_ALL;
				endcase
			end
			r.accumulator   = acc;
			r.carry_flag    = cy;
			r.latched_acc   = acc_l;
			r.latched_carry = cy_l;
			r.adder_sum     = sum;
			r.acc_is_zero   = (acc_l == NIB_ZERO);
			r.sum_is_zero   = (sum == NIB_ZERO);
			return r;
		endfunction

		function void note_transfer(req_item_t op);
			expected_status_q.push_back(predict_status(op));
		endfunction

		function void check_field(string name, int unsigned exp, int unsigned got);
			if (exp != got) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, exp, got);
			end
		endfunction

		function void check_result(rsp_item_t got);
			rsp_item_t exp;
			if (expected_status_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result transfer %p", $time, got);
				return;
			end
			exp = expected_status_q.pop_front();
			check_field("initializer_value", exp.initializer_value, got.initializer_value);
			check_field("accumulator", exp.accumulator, got.accumulator);
			check_field("carry_flag", exp.carry_flag, got.carry_flag);
			check_field("latched_acc", exp.latched_acc, got.latched_acc);
			check_field("latched_carry", exp.latched_carry, got.latched_carry);
			check_field("adder_sum", exp.adder_sum, got.adder_sum);
			check_field("acc_is_zero", exp.acc_is_zero, got.acc_is_zero);
			check_field("sum_is_zero", exp.sum_is_zero, got.sum_is_zero);
		endfunction
	endclass

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_item_t req_data  = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp_data;

	alu_status_checker sb = new();
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	int unsigned cycle_cnt  = 0;

	nibble_alu_micro_op_datapath dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_transfer(req_data);
			if (rsp_valid && rsp_ready)
				sb.check_result(rsp_data);
		end
	end

	function automatic req_item_t micro_op(op_t code, logic [3:0] bus, logic [6:0] flg,
			kind_t kind);
		req_item_t it;
		it.operation   = code;
		it.bus_value   = bus;
		it.invert      = flg[6];
		it.force_one   = flg[5];
		it.save_acc    = flg[4];
		it.save_carry  = flg[3];
		it.shift_left  = flg[2];
		it.shift_right = flg[1];
		it.opa_high    = flg[0];
		it.insn_kind   = kind;
		return it;
	endfunction

	function automatic req_item_t rand_op(op_t code);
		logic [RAW_W-1:0] raw;
		req_item_t it;
		raw = RAW_W'($urandom);
		it = raw;
		it.operation = code;
		return it;
	endfunction

	task automatic send_op(input req_item_t it);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		req_data  <= it;
		do @(posedge clk); while (!req_ready);
		items_sent++;
	endtask

	task automatic send_instruction();
		req_item_t it;
		if ($urandom_range(0, 3) != 0)
			send_op(rand_op(OP_BEGIN));
		if ($urandom_range(0, 3) != 0)
			send_op(rand_op(OP_LOAD));
		send_op(rand_op(OP_SET_A));
		it = rand_op(OP_SET_CIN);
		it.force_one = ($urandom_range(0, 3) == 0);
		send_op(it);
		it = rand_op(OP_RUN);
		it.shift_left  = ($urandom_range(0, 3) == 0);
		it.shift_right = ($urandom_range(0, 3) == 0);
		send_op(it);
		if ($urandom_range(0, 2) != 0)
			send_op(rand_op(OP_LATCH));
		if ($urandom_range(0, 2) == 0)
			send_op(rand_op(OP_QUERY));
	endtask

	task automatic send_noise();
		logic [RAW_W-1:0] raw;
		repeat ($urandom_range(1, 4)) begin
			raw = RAW_W'($urandom);
			send_op(req_item_t'(raw));
		end
	endtask

	// receiver: own ready pattern plus one long hold-off to back the block up
	initial begin
		rx_mode_t mode;
		int unsigned len;
		bit held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && items_sent >= HOLD_AFTER) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
			end
			mode = rx_mode_t'($urandom_range(0, 2));
			len  = $urandom_range(4, 40);
			repeat (len) begin
				case (mode)
					RX_STEADY: rsp_ready <= 1'b1;
					RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
					default:   rsp_ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(micro_op(OP_BEGIN, 4'h0, '0, KIND_OTHER));
		send_op(micro_op(OP_LOAD, 4'hF, '0, KIND_OTHER));
		send_op(micro_op(OP_SET_A, 4'h0, '0, KIND_OTHER));
		send_op(micro_op(OP_SET_CIN, 4'h0, F_ONE, KIND_OTHER));
		send_op(micro_op(OP_RUN, 4'h0, F_SA | F_SC, KIND_OTHER));
		send_op(micro_op(OP_LATCH, 4'h0, F_OPA, KIND_DAA));
		send_op(micro_op(OP_QUERY, 4'h0, F_OPA, KIND_DAA));
		send_op(micro_op(OP_SET_A, 4'h0, F_INV, KIND_OTHER));
		send_op(micro_op(OP_LOAD, 4'h9, '0, KIND_OTHER));
		send_op(micro_op(OP_SET_CIN, 4'h0, F_INV, KIND_OTHER));
		send_op(micro_op(OP_RUN, 4'h0, F_INV | F_SHL | F_SHR, KIND_OTHER));
		send_op(micro_op(OP_LATCH, 4'h0, '0, KIND_OTHER));
		send_op(micro_op(OP_QUERY, 4'h0, F_OPA, KIND_KBP));
		send_op(micro_op(OP_QUERY, 4'h0, F_OPA, KIND_DAA));
		send_op(micro_op(OP_RUN, 4'h0, F_SHR | F_SA | F_SC, KIND_OTHER));
		send_op(micro_op(OP_LATCH, 4'h0, '0, KIND_OTHER));
		send_op(micro_op(OP_QUERY, 4'h0, F_OPA, KIND_KBP));
		send_op(micro_op(OP_QUERY, 4'h0, '0, KIND_KBP));
		send_op(micro_op(OP_RUN, 4'h0, F_SC, KIND_DAA));
		send_op(micro_op(op_t'(OP_UNUSED), 4'hA, 7'h7F, KIND_KBP));
		send_op(micro_op(OP_QUERY, 4'h5, F_OPA, KIND_TCS));
		send_op(micro_op(OP_QUERY, 4'h0, F_OPA, KIND_OTHER));

		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 4) != 0)
				send_instruction();
			else
				send_noise();
		end
		req_valid <= 1'b0;

		while (sb.expected_status_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.expected_status_q.size() != 0)
			sb.errors++;

		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
